### sv/ow_pkg.sv
// ----------------------------------------------------------------------------
// ow_pkg
// Shared types, constants and timing helpers of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package ow_pkg;

	// width of the slot timer; durations saturate at 2^TIMER_BITS ticks
	localparam int TIMER_BITS = 10;
	localparam int CW         = TIMER_BITS + 1;
	localparam int TSPAN      = 1 << TIMER_BITS;
	localparam int TMAX       = TSPAN - 1;

	// widest configuration register
	localparam int CFG_DW = 10;

	// request codes
	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_RESET = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_READ  = 3'd3;
	localparam logic [2:0] REQ_TEMP  = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
	localparam logic [2:0] CFG_RELEASE_WAIT  = 3'd1;
	localparam logic [2:0] CFG_PRES_LIMIT    = 3'd2;
	localparam logic [2:0] CFG_LONG_SLOT     = 3'd3;
	localparam logic [2:0] CFG_SHORT_LOW     = 3'd4;
	localparam logic [2:0] CFG_READ_SAMPLE   = 3'd5;
	localparam logic [2:0] CFG_READ_RECOVERY = 3'd6;

	// reset values of the configuration registers
	localparam logic [9:0] RST_RESET_LOW     = 10'd750;
	localparam logic [7:0] RST_RELEASE_WAIT  = 8'd20;
	localparam logic [9:0] RST_PRES_LIMIT    = 10'd200;
	localparam logic [7:0] RST_LONG_SLOT     = 8'd60;
	localparam logic [3:0] RST_SHORT_LOW     = 4'd2;
	localparam logic [3:0] RST_READ_SAMPLE   = 4'd2;
	localparam logic [7:0] RST_READ_RECOVERY = 8'd50;

	// rom commands of the temperature sequence
	localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
	localparam logic [7:0] CMD_CONVERT      = 8'h44;
	localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

	// sequence steps of the temperature read
	localparam logic [3:0] STEP_NONE     = 4'd0;
	localparam logic [3:0] STEP_FIRST    = 4'd1;
	localparam logic [3:0] STEP_SKIP_A   = 4'd2;
	localparam logic [3:0] STEP_CONVERT  = 4'd3;
	localparam logic [3:0] STEP_RESET_B  = 4'd4;
	localparam logic [3:0] STEP_SKIP_B   = 4'd5;
	localparam logic [3:0] STEP_SCRATCH  = 4'd6;
	localparam logic [3:0] STEP_READ_LO  = 4'd7;
	localparam logic [3:0] STEP_READ_HI  = 4'd8;

	typedef struct packed {
		logic [9:0] reset_low_ticks;
		logic [7:0] release_wait_ticks;
		logic [9:0] presence_limit_ticks;
		logic [7:0] long_slot_ticks;
		logic [3:0] short_low_ticks;
		logic [3:0] read_sample_ticks;
		logic [7:0] read_recovery_ticks;
	} cfg_t;

	typedef struct packed {
		logic               drive_low;
		logic               busy_res;
		logic               done_res;
		logic               presence_fail;
		logic [7:0]         read_data;
		logic signed [15:0] temperature_raw;
	} res_t;

	// duration in ticks: zero acts as one, long values saturate at the timer span
	function automatic logic [CW-1:0] cap_dur(input logic [9:0] d);
		logic [16:0] dw;
		dw = 17'(d);
		if (d == 10'd0)
			cap_dur = CW'(1);
		else if (dw > 17'(TSPAN))
			cap_dur = CW'(TSPAN);
		else
			cap_dur = CW'(dw);
	endfunction

	// true on the last tick of a timed phase
	function automatic logic is_last(input logic [TIMER_BITS-1:0] tc, input logic [9:0] d);
		is_last = (CW'(tc) + CW'(1)) >= cap_dur(d);
	endfunction

	// presence timeout limited to the timer range
	function automatic logic [TIMER_BITS-1:0] pres_lim(input logic [9:0] d);
		logic [16:0] dw;
		dw = 17'(d);
		if (dw > 17'(TMAX))
			pres_lim = TIMER_BITS'(TMAX);
		else
			pres_lim = TIMER_BITS'(dw);
	endfunction

	// command byte sent at a write step of the temperature sequence
	function automatic logic [7:0] seq_byte(input logic [3:0] step);
		unique case (step)
			STEP_SKIP_A, STEP_SKIP_B: seq_byte = CMD_SKIP_ROM;
			STEP_CONVERT:             seq_byte = CMD_CONVERT;
			STEP_SCRATCH:             seq_byte = CMD_READ_SCRATCH;
			default:                  seq_byte = 8'h00;
		endcase
	endfunction

endpackage

### sv/ow_if.sv
// ----------------------------------------------------------------------------
// ow_req_if / ow_res_if
// Valid/ready channels carrying tick items and result items.
// ----------------------------------------------------------------------------
interface ow_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] write_data;
	logic       bus_level;

	modport source (output valid, output req_type, output write_data, output bus_level,
		input ready);
	modport sink (input valid, input req_type, input write_data, input bus_level,
		output ready);
endinterface

interface ow_res_if;
	logic               valid;
	logic               ready;
	logic               drive_low;
	logic               busy_res;
	logic               done_res;
	logic               presence_fail;
	logic [7:0]         read_data;
	logic signed [15:0] temperature_raw;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output presence_fail, output read_data, output temperature_raw, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input presence_fail, input read_data, input temperature_raw, output ready);
endinterface

### sv/ow_cfg.sv
// ----------------------------------------------------------------------------
// ow_cfg
// Timing configuration registers with their reset values.
// ----------------------------------------------------------------------------
module ow_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [2:0]                cfg_index,
	input  logic [ow_pkg::CFG_DW-1:0] cfg_data,
	output ow_pkg::cfg_t              cfg
);
	import ow_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks      <= RST_RESET_LOW;
			cfg_q.release_wait_ticks   <= RST_RELEASE_WAIT;
			cfg_q.presence_limit_ticks <= RST_PRES_LIMIT;
			cfg_q.long_slot_ticks      <= RST_LONG_SLOT;
			cfg_q.short_low_ticks      <= RST_SHORT_LOW;
			cfg_q.read_sample_ticks    <= RST_READ_SAMPLE;
			cfg_q.read_recovery_ticks  <= RST_READ_RECOVERY;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_RESET_LOW:     cfg_q.reset_low_ticks      <= 10'(cfg_data);
				CFG_RELEASE_WAIT:  cfg_q.release_wait_ticks   <= 8'(cfg_data);
				CFG_PRES_LIMIT:    cfg_q.presence_limit_ticks <= 10'(cfg_data);
				CFG_LONG_SLOT:     cfg_q.long_slot_ticks      <= 8'(cfg_data);
				CFG_SHORT_LOW:     cfg_q.short_low_ticks      <= 4'(cfg_data);
				CFG_READ_SAMPLE:   cfg_q.read_sample_ticks    <= 4'(cfg_data);
				CFG_READ_RECOVERY: cfg_q.read_recovery_ticks  <= 8'(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/ow_core.sv
// ----------------------------------------------------------------------------
// ow_core
// Bus phase state machine: one tick of bus time per accepted item.
// ----------------------------------------------------------------------------
module ow_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_en,
	input  logic [2:0]    req_type,
	input  logic [7:0]    write_data,
	input  logic          bus_level,
	input  ow_pkg::cfg_t  cfg,
	output ow_pkg::res_t  res
);
	import ow_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_RST_LOW, PH_RST_REL, PH_PRES_LOW, PH_PRES_HIGH,
		PH_WR_LOW, PH_WR_HIGH, PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
	} phase_t;

	phase_t                ph_q, ph;
	logic [TIMER_BITS-1:0] tc_q, tc;
	logic [2:0]            bi_q, bi;
	logic [7:0]            sb_q, sb;
	logic [3:0]            st_q, st;
	logic [7:0]            lbl_q, lbl;
	logic [15:0]           tw_q, tw;
	logic                  pf_q, pf;
	logic [7:0]            lr_q, lr;
	logic                  fin, drv, item_end, active, bit0;
	logic [TIMER_BITS-1:0] lim;

	always_comb begin
		ph = ph_q; tc = tc_q; bi = bi_q; sb = sb_q; st = st_q;
		lbl = lbl_q; tw = tw_q; pf = pf_q; lr = lr_q;
		fin = 1'b0; drv = 1'b0; item_end = 1'b0;
		lim = pres_lim(cfg.presence_limit_ticks);

		// request from idle: this tick is already the first of the operation
		if (ph_q == PH_IDLE && (req_type == REQ_RESET || req_type == REQ_WRITE ||
			req_type == REQ_READ || req_type == REQ_TEMP)) begin
			bi = 3'd0;
			tc = '0;
			st = STEP_NONE;
			if (req_type == REQ_TEMP) begin
				st = STEP_FIRST;
				ph = PH_RST_LOW;
			end else if (req_type == REQ_RESET) begin
				ph = PH_RST_LOW;
			end else if (req_type == REQ_WRITE) begin
				sb = write_data;
				ph = PH_WR_LOW;
			end else begin
				sb = 8'h00;
				ph = PH_RD_LOW;
			end
		end

		active = (ph != PH_IDLE);
		bit0   = sb[0];

		if (active) begin
			unique case (ph)
				PH_RST_LOW: begin
					drv = 1'b1;
					if (is_last(tc, cfg.reset_low_ticks)) begin
						tc = '0;
						ph = (cfg.release_wait_ticks == 8'd0) ? PH_PRES_LOW : PH_RST_REL;
					end else
						tc = tc + 1'b1;
				end
				PH_RST_REL: begin
					if (is_last(tc, 10'(cfg.release_wait_ticks))) begin
						tc = '0;
						ph = PH_PRES_LOW;
					end else
						tc = tc + 1'b1;
				end
				PH_PRES_LOW, PH_PRES_HIGH: begin
					if (lim == '0) begin
						pf = 1'b1;
						item_end = 1'b1;
					end else if (bus_level == (ph == PH_PRES_HIGH)) begin
						if (ph == PH_PRES_HIGH) begin
							pf = 1'b0;
							item_end = 1'b1;
						end else begin
							tc = '0;
							ph = PH_PRES_HIGH;
						end
					end else begin
						tc = tc + 1'b1;
						if (tc >= lim) begin
							pf = 1'b1;
							item_end = 1'b1;
						end
					end
				end
				PH_WR_LOW: begin
					drv = 1'b1;
					if (is_last(tc, bit0 ? 10'(cfg.short_low_ticks)
						: 10'(cfg.long_slot_ticks))) begin
						tc = '0;
						ph = PH_WR_HIGH;
					end else
						tc = tc + 1'b1;
				end
				PH_WR_HIGH: begin
					if (is_last(tc, bit0 ? 10'(cfg.long_slot_ticks)
						: 10'(cfg.short_low_ticks))) begin
						sb = sb >> 1;
						if (bi == 3'd7)
							item_end = 1'b1;
						else begin
							bi = bi + 1'b1;
							tc = '0;
							ph = PH_WR_LOW;
						end
					end else
						tc = tc + 1'b1;
				end
				PH_RD_LOW: begin
					drv = 1'b1;
					if (is_last(tc, 10'(cfg.short_low_ticks))) begin
						tc = '0;
						ph = (cfg.read_sample_ticks == 4'd0) ? PH_RD_REC : PH_RD_WAIT;
					end else
						tc = tc + 1'b1;
				end
				PH_RD_WAIT: begin
					if (is_last(tc, 10'(cfg.read_sample_ticks))) begin
						tc = '0;
						ph = PH_RD_REC;
					end else
						tc = tc + 1'b1;
				end
				PH_RD_REC: begin
					// sample on the first recovery tick, lsb arrives first
					if (tc == '0)
						sb = {bus_level, sb[7:1]};
					if (is_last(tc, 10'(cfg.read_recovery_ticks))) begin
						if (bi == 3'd7) begin
							lr = sb;
							item_end = 1'b1;
						end else begin
							bi = bi + 1'b1;
							tc = '0;
							ph = PH_RD_LOW;
						end
					end else
						tc = tc + 1'b1;
				end
				default: begin
					tc = '0;
					ph = PH_IDLE;
				end
			endcase
		end

		// end of one byte or reset item: advance the temperature sequence or finish
		if (item_end) begin
			if (st == STEP_READ_LO)
				lbl = lr;
			if (st == STEP_READ_HI)
				tw = {lr, lbl};
			tc = '0;
			if (st >= STEP_FIRST && st <= STEP_READ_LO) begin
				st = st + 1'b1;
				bi = 3'd0;
				if (st == STEP_RESET_B)
					ph = PH_RST_LOW;
				else if (st == STEP_READ_LO || st == STEP_READ_HI) begin
					sb = 8'h00;
					ph = PH_RD_LOW;
				end else begin
					sb = seq_byte(st);
					ph = PH_WR_LOW;
				end
			end else begin
				st  = STEP_NONE;
				ph  = PH_IDLE;
				fin = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			tc_q  <= '0;
			bi_q  <= 3'd0;
			sb_q  <= 8'h00;
			st_q  <= STEP_NONE;
			lbl_q <= 8'h00;
			tw_q  <= 16'h0000;
			pf_q  <= 1'b0;
			lr_q  <= 8'h00;
		end else if (step_en) begin
			ph_q  <= ph;
			tc_q  <= tc;
			bi_q  <= bi;
			sb_q  <= sb;
			st_q  <= st;
			lbl_q <= lbl;
			tw_q  <= tw;
			pf_q  <= pf;
			lr_q  <= lr;
		end
	end

	always_comb begin
		res.drive_low       = drv;
		res.busy_res        = active && !fin;
		res.done_res        = fin;
		res.presence_fail   = pf;
		res.read_data       = lr;
		res.temperature_raw = signed'(tw);
	end

endmodule

### sv/one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// 1-Wire bus master advanced by one microsecond tick per input item.
// ----------------------------------------------------------------------------
// Each item on req_ch is one microsecond of bus time: it carries the sampled
// line level and an optional request (reset+presence, write byte, read byte or
// the full temperature read). The block answers every item with exactly one
// result item on res_ch that tells whether to pull the bus low for that tick,
// plus busy/done status, the presence outcome, the last read byte and the last
// raw temperature word (signed, 1/16 degree units). Throughput is one item per
// clock while res_ch is ready: the phase machine in ow_core works out the next
// state and result of a tick, and an output register holds the result, so a
// new item is taken in the same cycle an earlier result leaves or while that
// register is empty; its result shows in the cycle after. Requests made while
// an operation runs are ignored, as are request codes above the temperature
// read. The user must write timing registers through the cfg port only while
// the block is idle (not enforced); durations saturate at 2^TIMER_BITS ticks.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	ow_req_if.sink                    req_ch,
	ow_res_if.source                  res_ch,
	input  logic                      cfg_wr_en,
	input  logic [2:0]                cfg_index,
	input  logic [ow_pkg::CFG_DW-1:0] cfg_data
);
	import ow_pkg::*;

	cfg_t cfg;
	res_t core_res;
	res_t res_q;
	logic res_vld_q;
	logic accept;

	// output register empties or drains this cycle: take the next tick
	assign req_ch.ready = !res_vld_q || res_ch.ready;
	assign accept       = req_ch.valid && req_ch.ready;

	ow_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// state only moves on an accepted tick
	ow_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (accept),
		.req_type   (req_ch.req_type),
		.write_data (req_ch.write_data),
		.bus_level  (req_ch.bus_level),
		.cfg        (cfg),
		.res        (core_res)
	);

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= accept || (res_vld_q && !res_ch.ready);
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= core_res;
		end
	end

	assign res_ch.valid           = res_vld_q;
	assign res_ch.drive_low       = res_q.drive_low;
	assign res_ch.busy_res        = res_q.busy_res;
	assign res_ch.done_res        = res_q.done_res;
	assign res_ch.presence_fail   = res_q.presence_fail;
	assign res_ch.read_data       = res_q.read_data;
	assign res_ch.temperature_raw = res_q.temperature_raw;

endmodule
